### hw/rtl/vn_pkg.sv
// Shared types, widths and arithmetic step functions for the vector normalizer.
// Used by vn_isqrt, vn_lane and vector3_normalizer_core; depends on nothing.
`default_nettype none

package vn_pkg;

    // Component width and fraction bits of the unit result.
    localparam int COMP_W = 16;
    localparam int FRAC_BITS = 14;

    // Derived widths.
    localparam int UNIT_W = FRAC_BITS + 2;
    localparam int MAG_W = FRAC_BITS + 1;
    localparam int SUM_W = 2 * COMP_W;
    localparam int QUO_W = 2 * FRAC_BITS + 3;
    localparam int ROOT_W = (COMP_W > FRAC_BITS + 2) ? COMP_W : FRAC_BITS + 2;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 4;

    // Pipeline depths.
    localparam int DIV_STEPS = QUO_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int PIPE_DEPTH = 3 + DIV_STEPS + ROOT_STEPS;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic [COMP_W-1:0] length;
        logic was_zero;
    } vn_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic qbit;
    } div_step_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } root_step_t;

    // One restoring division step on an already shifted partial remainder.
    function automatic div_step_t div_step(input logic [SUM_W:0] x,
                                           input logic [SUM_W-1:0] s);
        div_step_t r;
        logic [SUM_W:0] diff;
        diff = x - {1'b0, s};
        if (x >= {1'b0, s}) begin
            r.rem = diff[SUM_W-1:0];
            r.qbit = 1'b1;
        end else begin
            r.rem = x[SUM_W-1:0];
            r.qbit = 1'b0;
        end
        return r;
    endfunction

    // One digit of the integer square root: bring down two radicand bits.
    function automatic root_step_t root_step(input root_step_t st);
        root_step_t r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {st.rem[REM_W-3:0], st.rad[RAD_W-1:RAD_W-2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, st.root, 2'b01};
        r.rad = {st.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            r.rem = rem_sh - trial;
            r.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem = rem_sh;
            r.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vector3_normalizer_core.sv
// Vector normalizer top level: input stage, three lanes, length root and merge.
// Depends on vn_pkg, vn_lane and vn_isqrt.
//
// Usage:
//   s_valid/s_ready/s_data carries one vector (comp_x, comp_y, comp_z) per
//   transfer. m_valid/m_ready/m_data returns its unit vector in Q2.14, the
//   floor of its length and a zero flag, one result per input transfer, in order.
//   Each vector passes three front stages (magnitude, square, sum),
//   31 restoring division stages and 16 square root stages in each lane,
//   and the output register.
//   Throughput is one vector per cycle; the whole pipeline advances together.
//   When the receiver stalls with a result waiting, every stage holds and
//   s_ready drops; while the output register is empty or being taken, a
//   new transfer is accepted every cycle.
//   A synchronous active-low reset on aresetn clears the valid bits and so empties
//   the pipeline; data registers are not reset, and the block has no configuration.
`default_nettype none

module vector3_normalizer_core
    import vn_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire vn_in_t  s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output vn_out_t      m_data
);

    typedef struct packed {
        logic [2:0] neg;
        logic zero;
    } side_t;

    logic en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    side_t side_reg [PIPE_DEPTH];
    logic [COMP_W-1:0] mag_reg [3];
    logic [SUM_W-1:0] sq_reg [3];
    logic [SUM_W-1:0] sq2_reg [3];
    logic [SUM_W-1:0] sum_reg;
    logic [ROOT_W-1:0] len_root;
    logic [ROOT_W-1:0] len_reg [DIV_STEPS];
    logic [MAG_W-1:0] lane_mag [3];
    logic signed [COMP_W-1:0] comp [3];
    logic m_valid_reg;
    vn_out_t m_data_reg;
    vn_out_t m_data_next;
    logic signed [UNIT_W-1:0] unit_val [3];

    assign comp[0] = s_data.comp_x;
    assign comp[1] = s_data.comp_y;
    assign comp[2] = s_data.comp_z;

    // The pipeline moves whenever the output register is free or being taken.
    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Valid bits for every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
            m_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // Signs and zero flag travel alongside the arithmetic.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{neg: {comp[2][COMP_W-1], comp[1][COMP_W-1], comp[0][COMP_W-1]},
                             zero: (s_data.comp_x == '0) && (s_data.comp_y == '0)
                                   && (s_data.comp_z == '0)};
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Front stages: magnitude, square, sum of squares.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= comp[i][COMP_W-1] ? COMP_W'(-comp[i]) : COMP_W'(comp[i]);
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
                sq2_reg[i] <= sq_reg[i];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Three lanes, one for each component.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        vn_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .sq       (sq2_reg[i]),
            .sum      (sum_reg),
            .unit_mag (lane_mag[i])
        );
    end

    // Length root runs beside the lanes and waits for their division stages.
    vn_isqrt u_len (
        .aclk     (aclk),
        .en       (en),
        .radicand ({{(RAD_W-SUM_W){1'b0}}, sum_reg}),
        .root     (len_root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg[0] <= len_root;
            for (int k = 1; k < DIV_STEPS; k++) begin
                len_reg[k] <= len_reg[k-1];
            end
        end
    end

    // Merge stage: apply signs and the zero-vector case.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (side_reg[PIPE_DEPTH-1].zero) begin
                unit_val[i] = '0;
            end else if (side_reg[PIPE_DEPTH-1].neg[i]) begin
                unit_val[i] = -$signed({1'b0, lane_mag[i]});
            end else begin
                unit_val[i] = $signed({1'b0, lane_mag[i]});
            end
        end
        m_data_next.unit_x = unit_val[0];
        m_data_next.unit_y = unit_val[1];
        m_data_next.unit_z = unit_val[2];
        m_data_next.length = side_reg[PIPE_DEPTH-1].zero ? '0
                                                         : len_reg[DIV_STEPS-1][COMP_W-1:0];
        m_data_next.was_zero = side_reg[PIPE_DEPTH-1].zero;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // A zero vector gives all-zero unit components and length.
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.was_zero |-> m_data.unit_x == '0 && m_data.unit_y == '0
            && m_data.unit_z == '0 && m_data.length == '0)
        else $error("zero vector produced nonzero result");

    // A nonzero vector has length at least one.
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.was_zero |-> m_data.length != '0)
        else $error("nonzero vector produced zero length");

    // The x unit component never exceeds one in magnitude.
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.unit_x <= $signed(UNIT_W'(1 << FRAC_BITS))
            && m_data.unit_x >= -$signed(UNIT_W'(1 << FRAC_BITS)))
        else $error("unit component out of range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

### hw/rtl/vn_isqrt.sv
// Pipelined integer square root, one result digit per stage.
// Depends on vn_pkg for widths and the digit step function.
`default_nettype none

module vn_isqrt
    import vn_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    root_step_t stage_reg [ROOT_STEPS];

    // The first stage starts from a zero remainder and root.
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= root_step('{rad: radicand, rem: '0, root: '0});
        end
    end

    // Each following stage resolves one more root bit.
    for (genvar k = 1; k < ROOT_STEPS; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= root_step(stage_reg[k-1]);
            end
        end
    end

    assign root = stage_reg[ROOT_STEPS-1].root;

endmodule

`default_nettype wire

### hw/rtl/vn_lane.sv
// One normalizing lane: floor(a^2 * 2^(2F+2) / s), its square root, then rounding.
// Depends on vn_pkg and vn_isqrt.
`default_nettype none

module vn_lane
    import vn_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [SUM_W-1:0] sq,
    input  wire logic [SUM_W-1:0] sum,
    output logic      [MAG_W-1:0] unit_mag
);

    logic [SUM_W-1:0] rem_reg [DIV_STEPS];
    logic [SUM_W-1:0] sum_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic [ROOT_W-1:0] root;
    logic [MAG_W+1:0] rounded;
    div_step_t first_step;

    // First step: the square itself is the shifted remainder since sq <= sum.
    assign first_step = div_step({1'b0, sq}, sum);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= first_step.rem;
            sum_reg[0] <= sum;
            quo_reg[0] <= {{(QUO_W-1){1'b0}}, first_step.qbit};
        end
    end

    // Remaining quotient bits, one per stage; low dividend bits are zero.
    for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div
        div_step_t st;
        assign st = div_step({rem_reg[k-1], 1'b0}, sum_reg[k-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= st.rem;
                sum_reg[k] <= sum_reg[k-1];
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], st.qbit};
            end
        end
    end

    vn_isqrt u_root (
        .aclk     (aclk),
        .en       (en),
        .radicand ({{(RAD_W-QUO_W){1'b0}}, quo_reg[DIV_STEPS-1]}),
        .root     (root)
    );

    // The largest c with 2c-1 <= root is (root+1)/2.
    assign rounded = {1'b0, root[MAG_W:0]} + {{(MAG_W+1){1'b0}}, 1'b1};
    assign unit_mag = rounded[MAG_W:1];

endmodule

`default_nettype wire

### tb/sv/vector3_normalizer_core_tb.sv
// Testbench for vector3_normalizer_core: directed table, then random vectors
// checked against a behavioral normalizer. Depends on vn_pkg and the core.
`default_nettype none

module vector3_normalizer_core_tb;
    import vn_pkg::*;

    localparam int N_RANDOM = 1800;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vn_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vn_out_t m_data;

    // Directed row: a vector and, where it is obvious, its result.
    typedef struct {
        vn_in_t vec;
        logic typed;
        vn_out_t res;
    } vec_row_t;

    vn_out_t norm_queue[$];
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    vector3_normalizer_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Round(a * 2^FRAC_BITS / sqrt(s)) found bit by bit using exact integers.
    function automatic logic [FRAC_BITS:0] unit_magnitude(longint unsigned a,
                                                          longint unsigned s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned r;
        longint unsigned c;
        longint unsigned t;
        rhs = 128'(a * a) << (2 * FRAC_BITS + 2);
        r = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c <= (64'd1 << FRAC_BITS)) begin
                t = 2 * c - 1;
                lhs = 128'(t * t) * 128'(s);
                if (lhs <= rhs) r = c;
            end
        end
        return r[FRAC_BITS:0];
    endfunction

    // Floor square root of the sum of squares.
    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic vn_out_t normalize(vn_in_t v);
        vn_out_t o;
        longint signed comp[3];
        longint unsigned mag[3];
        longint unsigned sum;
        logic [UNIT_W-1:0] u[3];
        comp[0] = v.comp_x;
        comp[1] = v.comp_y;
        comp[2] = v.comp_z;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
            sum += mag[i] * mag[i];
        end
        o = '0;
        if (sum == 0) begin
            o.was_zero = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                u[i] = UNIT_W'(unit_magnitude(mag[i], sum));
                if (comp[i] < 0) u[i] = -u[i];
            end
            o.unit_x = u[0];
            o.unit_y = u[1];
            o.unit_z = u[2];
            o.length = COMP_W'(floor_root(sum));
        end
        return o;
    endfunction

    function automatic vn_out_t res_of(int ux, int uy, int uz, int len, bit z);
        vn_out_t o;
        o.unit_x = UNIT_W'(ux);
        o.unit_y = UNIT_W'(uy);
        o.unit_z = UNIT_W'(uz);
        o.length = COMP_W'(len);
        o.was_zero = z;
        return o;
    endfunction

    function automatic vec_row_t row(int x, int y, int z, bit typed, vn_out_t r);
        vec_row_t w;
        w.vec.comp_x = COMP_W'(x);
        w.vec.comp_y = COMP_W'(y);
        w.vec.comp_z = COMP_W'(z);
        w.typed = typed;
        w.res = r;
        return w;
    endfunction

    // Send one vector; the expectation is queued on the accepting edge.
    // Valid drops only while the sender idles, so back-to-back transfers keep it high.
    task automatic send_vector(vn_in_t v, vn_out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        norm_queue.push_back(want);
        @(negedge aclk);
    endtask

    // Random vector component: mix of full-range, small, mid-range and extreme values.
    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return COMP_W'($urandom_range(7)) - COMP_W'(3);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            2: return COMP_W'($urandom_range(511)) - COMP_W'(256);
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, checks each transfer against the oldest expectation.
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (norm_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %p", m_data);
            end else if (m_data !== norm_queue[0]) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("mismatch: expected %p got %p", norm_queue[0], m_data);
                void'(norm_queue.pop_front());
            end else begin
                void'(norm_queue.pop_front());
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("vector3_normalizer_core test failed");
            $finish;
        end
    end

    initial begin
        vec_row_t dir[$];
        vn_in_t v;
        dir.push_back(row(0, 0, 0, 1, res_of(0, 0, 0, 0, 1)));
        dir.push_back(row(1, 0, 0, 1, res_of(16384, 0, 0, 1, 0)));
        dir.push_back(row(0, -1, 0, 1, res_of(0, -16384, 0, 1, 0)));
        dir.push_back(row(0, 0, 32767, 1, res_of(0, 0, 16384, 32767, 0)));
        dir.push_back(row(-32768, 0, 0, 1, res_of(-16384, 0, 0, 32768, 0)));
        dir.push_back(row(0, -32768, 0, 1, res_of(0, -16384, 0, 32768, 0)));
        dir.push_back(row(0, 0, -32768, 1, res_of(0, 0, -16384, 32768, 0)));
        dir.push_back(row(3, 4, 0, 1, res_of(9830, 13107, 0, 5, 0)));
        dir.push_back(row(-32768, -32768, -32768, 0, '0));
        dir.push_back(row(32767, 32767, 32767, 0, '0));
        dir.push_back(row(32767, -32768, 32767, 0, '0));
        dir.push_back(row(1, 1, 1, 0, '0));
        dir.push_back(row(-1, 1, -1, 0, '0));
        dir.push_back(row(1, 1, 0, 0, '0));
        dir.push_back(row(2, 1, 2, 0, '0));
        dir.push_back(row(-21845, 10922, 5461, 0, '0));
        dir.push_back(row(1, 32767, 0, 0, '0));
        dir.push_back(row(-1, -2, 32767, 0, '0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, no idling.
        foreach (dir[i])
            send_vector(dir[i].vec, dir[i].typed ? dir[i].res : normalize(dir[i].vec));

        // Random phases with different idle and stall mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                v.comp_x = rand_comp();
                v.comp_y = rand_comp();
                v.comp_z = rand_comp();
                send_vector(v, normalize(v));
            end
        end
        s_valid <= 1'b0;

        while (norm_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d vectors: zero, axis-aligned, extreme and random mixes,",
                 results_seen);
        $display("with sender gaps and receiver stalls in separate and mixed phases.");
        if (mismatches == 0) begin
            $display("vector3_normalizer_core test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("vector3_normalizer_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/vn_pkg.sv
hw/rtl/vn_isqrt.sv
hw/rtl/vn_lane.sv
hw/rtl/vector3_normalizer_core.sv
tb/sv/vector3_normalizer_core_tb.sv
